>>> hdl/pdrb_pkg.sv
package pdrb_pkg;

    // Field widths
    localparam int CMD_W    = 3;
    localparam int TIME_W   = 32;
    localparam int LEVEL_W  = 8;
    localparam int RMS_W    = 16;
    localparam int DUTY_W   = 7;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Shared divider: Q16 span over a 16-bit divisor
    localparam int DIV_W     = 23;
    localparam int DIVS_W    = 16;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_MANUAL     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RAMP       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_BREATH_ON  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_BREATH_OFF = 3'd4;
    localparam logic [CMD_W-1:0] CMD_BUTTON     = 3'd5;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RAMP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BREATH = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BREATH_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BREATH_MIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BREATH_MAX    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE      = 2'd3;

    // Divider operand selects
    localparam logic [1:0] DIV_SEL_RAMP  = 2'd0;
    localparam logic [1:0] DIV_SEL_STEP  = 2'd2;

    // Behavior constants
    localparam logic [15:0]       STEP_PERIOD_MS  = 16'd10;
    localparam logic [3:0]        TABLE_ENTRIES   = 4'd5;
    localparam logic [DUTY_W-1:0] DUTY_MAX        = 7'd100;
    localparam logic [15:0]       RAMP_MIN_MS     = 16'd20;
    localparam logic [15:0]       PERIOD_MIN_MS   = 16'd200;

    // Reciprocal of STEP_PERIOD_MS: (x * STEP_RECIP) >> STEP_RECIP_SHIFT gives
    // x / STEP_PERIOD_MS exactly for any 16-bit x; retune both with the period
    localparam logic [31:0]       STEP_RECIP       = 32'd52429;
    localparam int                STEP_RECIP_SHIFT = 19;

    // Controller to datapath commands
    typedef struct packed {
        logic       load_item;
        logic       exec;
        logic       div_start;
        logic [1:0] div_sel;
        logic       ramp_apply;
        logic       breath_apply;
        logic       out_load;
    } pdrb_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [MODE_W-1:0] mode;
        logic              ramp_end;
        logic              breath_early;
        logic              div_done;
    } pdrb_sts_t;

    // Button duty table; entries past the fifth read full scale
    function automatic logic [DUTY_W-1:0] duty_lookup(input logic [2:0] idx);
        logic [DUTY_W-1:0] d;
        unique case (idx)
            3'd0:    d = 7'd0;
            3'd1:    d = 7'd10;
            3'd2:    d = 7'd30;
            3'd3:    d = 7'd60;
            default: d = 7'd100;
        endcase
        return d;
    endfunction

    function automatic logic [DUTY_W-1:0] duty_sat(input logic [DUTY_W-1:0] d);
        return (d > DUTY_MAX) ? DUTY_MAX : d;
    endfunction

endpackage

>>> hdl/pdrb_in_if.sv
interface pdrb_in_if;
    import pdrb_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [TIME_W-1:0]  now_ms;
    logic [LEVEL_W-1:0] level_value;
    logic [RMS_W-1:0]   ramp_ms;

    modport source (output valid, command, now_ms, level_value, ramp_ms, input ready);
    modport sink   (input valid, command, now_ms, level_value, ramp_ms, output ready);
endinterface

>>> hdl/pdrb_out_if.sv
interface pdrb_out_if;
    import pdrb_pkg::*;

    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty;
    logic [MODE_W-1:0] mode;
    logic              duty_written;

    modport source (output valid, duty, mode, duty_written, input ready);
    modport sink   (input valid, duty, mode, duty_written, output ready);
endinterface

>>> hdl/pdrb_cfg_if.sv
interface pdrb_cfg_if;
    import pdrb_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/pdrb_div.sv
module pdrb_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pdrb_pkg::DIV_W-1:0]    dividend,
    input  logic [pdrb_pkg::DIVS_W-1:0]   divisor,
    output logic                          done,
    output logic [pdrb_pkg::DIV_W-1:0]    quotient
);
    import pdrb_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIVS_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIVS_W-1:0]    dvs_reg, dvs_next;

    logic [DIVS_W:0]      trial;
    logic [DIVS_W:0]      trial_diff;
    logic                 fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial      = {rem_reg, quo_reg[DIV_W-1]};
    assign trial_diff = trial - {1'b0, dvs_reg};
    assign fits       = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial_diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operands
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hdl/pdrb_dp.sv
module pdrb_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pdrb_pkg::pdrb_cmd_t               cmd,
    output pdrb_pkg::pdrb_sts_t               sts,
    input  logic [pdrb_pkg::CMD_W-1:0]        item_command,
    input  logic [pdrb_pkg::TIME_W-1:0]       item_now_ms,
    input  logic [pdrb_pkg::LEVEL_W-1:0]      item_level_value,
    input  logic [pdrb_pkg::RMS_W-1:0]        item_ramp_ms,
    input  logic                              cfg_we,
    input  logic [pdrb_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [pdrb_pkg::CFG_DAT_W-1:0]    cfg_data,
    output logic [pdrb_pkg::DUTY_W-1:0]       out_duty,
    output logic [pdrb_pkg::MODE_W-1:0]       out_mode,
    output logic                              out_written
);
    import pdrb_pkg::*;

    // Configuration
    logic [15:0]       period_reg, period_next;
    logic [DUTY_W-1:0] bmin_reg, bmin_next;
    logic [DUTY_W-1:0] bmax_reg, bmax_next;
    logic [7:0]        debounce_reg, debounce_next;

    // Latched request
    logic [CMD_W-1:0]  icmd_reg, icmd_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [DUTY_W-1:0] level_reg, level_next;
    logic [RMS_W-1:0]  rms_reg, rms_next;

    // Engine state
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [DUTY_W-1:0] duty_reg, duty_next;
    logic [DUTY_W-1:0] ramp_from_reg, ramp_from_next;
    logic [DUTY_W-1:0] ramp_to_reg, ramp_to_next;
    logic [TIME_W-1:0] ramp_start_reg, ramp_start_next;
    logic [RMS_W-1:0]  ramp_len_reg, ramp_len_next;
    logic [TIME_W-1:0] br_last_reg, br_last_next;
    logic              br_rising_reg, br_rising_next;
    logic [DIV_W-1:0]  br_level_reg, br_level_next;
    logic [2:0]        btn_idx_reg, btn_idx_next;
    logic [TIME_W-1:0] btn_last_reg, btn_last_next;
    logic              written_reg, written_next;

    // Result payload
    logic [DUTY_W-1:0] out_duty_reg, out_duty_next;
    logic [MODE_W-1:0] out_mode_reg, out_mode_next;
    logic              out_written_reg, out_written_next;

    // Divider hookup
    logic [DIV_W-1:0]  div_dividend;
    logic [DIVS_W-1:0] div_divisor;
    logic              div_done;
    logic [DIV_W-1:0]  div_quo;

    // Ramp terms
    logic [TIME_W-1:0] ramp_dt;
    logic              ramp_end;
    logic              ramp_neg;
    logic [DUTY_W-1:0] ramp_mag;
    logic [DIV_W-1:0]  ramp_prod;
    logic [DUTY_W-1:0] ramp_v;

    // Breathing terms
    logic [TIME_W-1:0] br_dt;
    logic              br_early;
    logic [DUTY_W-1:0] br_hi;
    logic [DUTY_W-1:0] br_span;
    logic [15:0]       br_half;
    logic [15:0]       br_half_sat;
    logic [31:0]       br_recip;
    logic [15:0]       br_steps;
    logic [DIV_W+1:0]  br_hi_q;
    logic [DIV_W+1:0]  br_lo_q;
    logic [DIV_W+1:0]  br_sum;
    logic [DIV_W+1:0]  br_lvl_a;
    logic              br_rise_a;
    logic [DIV_W+1:0]  br_lvl_b;
    logic              br_rise_b;

    // Button terms
    logic [TIME_W-1:0] btn_dt;
    logic [2:0]        btn_inc;
    logic [2:0]        btn_new;

    // Ramp interpolation: |to - from| * dt, sign applied after the divide
    assign ramp_dt   = now_reg - ramp_start_reg;
    assign ramp_end  = (ramp_dt >= {16'b0, ramp_len_reg}) || (ramp_len_reg == '0);
    assign ramp_neg  = (ramp_to_reg < ramp_from_reg);
    assign ramp_mag  = ramp_neg ? (ramp_from_reg - ramp_to_reg) : (ramp_to_reg - ramp_from_reg);
    assign ramp_prod = {16'b0, ramp_mag} * {7'b0, ramp_dt[15:0]};
    assign ramp_v    = ramp_neg ? (ramp_from_reg - div_quo[DUTY_W-1:0])
                                : (ramp_from_reg + div_quo[DUTY_W-1:0]);

    // Breathing limits and step count
    assign br_dt       = now_reg - br_last_reg;
    assign br_early    = (br_dt < {16'b0, STEP_PERIOD_MS});
    assign br_hi       = (bmax_reg > bmin_reg) ? bmax_reg : (bmin_reg + 1'b1);
    assign br_span     = br_hi - bmin_reg;
    assign br_half     = {1'b0, period_reg[15:1]};
    assign br_half_sat = (br_half < STEP_PERIOD_MS) ? STEP_PERIOD_MS : br_half;
    assign br_hi_q     = {2'b0, br_hi, 16'b0};
    assign br_lo_q     = {2'b0, bmin_reg, 16'b0};

    // Steps per half period by reciprocal multiply
    assign br_recip    = {16'b0, br_half_sat} * STEP_RECIP;
    assign br_steps    = 16'(br_recip >> STEP_RECIP_SHIFT);

    // Advance the level one step, then clamp and reverse at either limit
    always_comb
    begin
        br_sum = br_rising_reg ? ({2'b0, br_level_reg} + {2'b0, div_quo})
                               : ({2'b0, br_level_reg} - {2'b0, div_quo});
        if ($signed(br_sum) >= $signed(br_hi_q))
        begin
            br_lvl_a  = br_hi_q;
            br_rise_a = 1'b0;
        end
        else
        begin
            br_lvl_a  = br_sum;
            br_rise_a = br_rising_reg;
        end
        if ($signed(br_lvl_a) <= $signed(br_lo_q))
        begin
            br_lvl_b  = br_lo_q;
            br_rise_b = 1'b1;
        end
        else
        begin
            br_lvl_b  = br_lvl_a;
            br_rise_b = br_rise_a;
        end
    end

    // Button table index
    assign btn_dt  = now_reg - btn_last_reg;
    assign btn_inc = btn_idx_reg + 1'b1;
    assign btn_new = ({1'b0, btn_inc} >= TABLE_ENTRIES) ? 3'd0 : btn_inc;

    // Select divider operands
    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_SEL_RAMP:
            begin
                div_dividend = ramp_prod;
                div_divisor  = ramp_len_reg;
            end
            DIV_SEL_STEP:
            begin
                div_dividend = {br_span, 16'b0};
                div_divisor  = br_steps;
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = 16'd1;
            end
        endcase
    end

    pdrb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Next state
    always_comb
    begin
        period_next      = period_reg;
        bmin_next        = bmin_reg;
        bmax_next        = bmax_reg;
        debounce_next    = debounce_reg;
        icmd_next        = icmd_reg;
        now_next         = now_reg;
        level_next       = level_reg;
        rms_next         = rms_reg;
        mode_next        = mode_reg;
        duty_next        = duty_reg;
        ramp_from_next   = ramp_from_reg;
        ramp_to_next     = ramp_to_reg;
        ramp_start_next  = ramp_start_reg;
        ramp_len_next    = ramp_len_reg;
        br_last_next     = br_last_reg;
        br_rising_next   = br_rising_reg;
        br_level_next    = br_level_reg;
        btn_idx_next     = btn_idx_reg;
        btn_last_next    = btn_last_reg;
        written_next     = written_reg;
        out_duty_next    = out_duty_reg;
        out_mode_next    = out_mode_reg;
        out_written_next = out_written_reg;

        // Take configuration writes, saturated
        if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_BREATH_PERIOD:
                    period_next = (cfg_data < PERIOD_MIN_MS) ? PERIOD_MIN_MS : cfg_data;
                CFG_BREATH_MIN:
                    bmin_next = duty_sat(cfg_data[DUTY_W-1:0]);
                CFG_BREATH_MAX:
                    bmax_next = duty_sat(cfg_data[DUTY_W-1:0]);
                CFG_DEBOUNCE:
                    debounce_next = cfg_data[7:0];
                default:
                    debounce_next = debounce_reg;
            endcase
        end

        // Latch the request, clamp the level
        if (cmd.load_item)
        begin
            icmd_next    = item_command;
            now_next     = item_now_ms;
            level_next   = (item_level_value > {1'b0, DUTY_MAX}) ? DUTY_MAX
                                                               : item_level_value[DUTY_W-1:0];
            rms_next     = item_ramp_ms;
            written_next = 1'b0;
        end

        // Commands that finish without the divider
        if (cmd.exec)
        begin
            unique case (icmd_reg)
                CMD_TICK:
                begin
                    if (mode_reg == MODE_RAMP)
                    begin
                        mode_next    = MODE_MANUAL;
                        duty_next    = ramp_to_reg;
                        written_next = 1'b1;
                    end
                end
                CMD_MANUAL:
                begin
                    mode_next    = MODE_MANUAL;
                    duty_next    = level_reg;
                    written_next = 1'b1;
                end
                CMD_RAMP:
                begin
                    mode_next       = MODE_RAMP;
                    ramp_from_next  = duty_reg;
                    ramp_to_next    = level_reg;
                    ramp_start_next = now_reg;
                    ramp_len_next   = (rms_reg < RAMP_MIN_MS) ? RAMP_MIN_MS : rms_reg;
                end
                CMD_BREATH_ON:
                begin
                    mode_next      = MODE_BREATH;
                    br_last_next   = now_reg;
                    br_rising_next = 1'b1;
                    br_level_next  = {bmin_reg, 16'b0};
                    duty_next      = bmin_reg;
                    written_next   = 1'b1;
                end
                CMD_BREATH_OFF:
                    mode_next = MODE_MANUAL;
                CMD_BUTTON:
                begin
                    if (btn_dt >= {24'b0, debounce_reg})
                    begin
                        btn_last_next = now_reg;
                        btn_idx_next  = btn_new;
                        mode_next     = MODE_MANUAL;
                        duty_next     = duty_lookup(btn_new);
                        written_next  = 1'b1;
                    end
                end
                default:
                    written_next = written_reg;
            endcase
        end

        // Apply the interpolated ramp level
        if (cmd.ramp_apply)
        begin
            duty_next    = duty_sat(ramp_v);
            written_next = 1'b1;
        end

        // Apply one breathing step
        if (cmd.breath_apply)
        begin
            br_last_next   = br_last_reg + {16'b0, STEP_PERIOD_MS};
            br_level_next  = br_lvl_b[DIV_W-1:0];
            br_rising_next = br_rise_b;
            duty_next      = duty_sat(br_lvl_b[DIV_W-1:16]);
            written_next   = 1'b1;
        end

        // Capture the result
        if (cmd.out_load)
        begin
            out_duty_next    = duty_reg;
            out_mode_next    = mode_reg;
            out_written_next = written_reg;
        end
    end

    // Engine state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg     <= 16'd2000;
            bmin_reg       <= 7'd0;
            bmax_reg       <= 7'd100;
            debounce_reg   <= 8'd30;
            mode_reg       <= MODE_MANUAL;
            duty_reg       <= '0;
            ramp_from_reg  <= '0;
            ramp_to_reg    <= '0;
            ramp_start_reg <= '0;
            ramp_len_reg   <= '0;
            br_last_reg    <= '0;
            br_rising_reg  <= 1'b1;
            br_level_reg   <= '0;
            btn_idx_reg    <= '0;
            btn_last_reg   <= '0;
            written_reg    <= 1'b0;
        end
        else
        begin
            period_reg     <= period_next;
            bmin_reg       <= bmin_next;
            bmax_reg       <= bmax_next;
            debounce_reg   <= debounce_next;
            mode_reg       <= mode_next;
            duty_reg       <= duty_next;
            ramp_from_reg  <= ramp_from_next;
            ramp_to_reg    <= ramp_to_next;
            ramp_start_reg <= ramp_start_next;
            ramp_len_reg   <= ramp_len_next;
            br_last_reg    <= br_last_next;
            br_rising_reg  <= br_rising_next;
            br_level_reg   <= br_level_next;
            btn_idx_reg    <= btn_idx_next;
            btn_last_reg   <= btn_last_next;
            written_reg    <= written_next;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        icmd_reg        <= icmd_next;
        now_reg         <= now_next;
        level_reg       <= level_next;
        rms_reg         <= rms_next;
        out_duty_reg    <= out_duty_next;
        out_mode_reg    <= out_mode_next;
        out_written_reg <= out_written_next;
    end

    assign sts.command      = icmd_reg;
    assign sts.mode         = mode_reg;
    assign sts.ramp_end     = ramp_end;
    assign sts.breath_early = br_early;
    assign sts.div_done     = div_done;

    assign out_duty    = out_duty_reg;
    assign out_mode    = out_mode_reg;
    assign out_written = out_written_reg;

endmodule

>>> hdl/pdrb_ctrl.sv
module pdrb_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  pdrb_pkg::pdrb_sts_t   sts,
    output pdrb_pkg::pdrb_cmd_t   cmd
);
    import pdrb_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_EXEC      = 3'd1;
    localparam logic [2:0] S_DIV_RAMP  = 3'd2;
    localparam logic [2:0] S_DIV_STEP  = 3'd4;
    localparam logic [2:0] S_DONE      = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       in_fire;
    logic       is_tick;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign is_tick  = (sts.command == CMD_TICK);

    // Sequence one request through decode, divide and result capture
    always_comb
    begin
        cmd        = '0;
        cmd.div_sel = DIV_SEL_RAMP;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                priority if (is_tick && (sts.mode == MODE_RAMP) && !sts.ramp_end)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SEL_RAMP;
                    state_next    = S_DIV_RAMP;
                end
                else if (is_tick && (sts.mode == MODE_BREATH) && !sts.breath_early)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SEL_STEP;
                    state_next    = S_DIV_STEP;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DIV_RAMP:
            begin
                if (sts.div_done)
                begin
                    cmd.ramp_apply = 1'b1;
                    state_next     = S_DONE;
                end
            end
            S_DIV_STEP:
            begin
                if (sts.div_done)
                begin
                    cmd.breath_apply = 1'b1;
                    state_next       = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Hold the result until taken
    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_EXEC))
        else $error("accepted request did not move to decode");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> ((state_reg == S_DIV_RAMP) || (state_reg == S_DIV_STEP)))
        else $error("divider finished with no divide pending");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("result dropped before it was taken");

endmodule

>>> hdl/pwm_duty_ramp_breath_engine.sv
// PWM duty engine with manual, linear ramp and triangular breathing modes.
// Each request on item carries a command and a millisecond timestamp and
// yields exactly one result on result (duty, mode, duty_written). Requests
// are handled one at a time; a new request is taken while the previous
// result still waits. Set manual, start ramp, breath on/off, button and
// ticks that need no arithmetic finish without the divider. A ramp tick
// or a breathing step goes through the shared 23-step
// restoring divider (one divide for the ramp level or for the breathing step
// size; the breathing step count comes from a reciprocal multiply). A result
// left waiting holds off the request after the next one. Configuration
// writes on cfg are always taken and must only be issued while no request is
// in flight.
module pwm_duty_ramp_breath_engine (
    input logic         clk,
    input logic         rst_n,
    pdrb_in_if.sink     item,
    pdrb_out_if.source  result,
    pdrb_cfg_if.sink    cfg
);
    import pdrb_pkg::*;

    pdrb_cmd_t cmd;
    pdrb_sts_t sts;

    assign cfg.ready = 1'b1;

    pdrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pdrb_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .item_command     (item.command),
        .item_now_ms      (item.now_ms),
        .item_level_value (item.level_value),
        .item_ramp_ms     (item.ramp_ms),
        .cfg_we           (cfg.valid),
        .cfg_idx          (cfg.index),
        .cfg_data         (cfg.data),
        .out_duty         (result.duty),
        .out_mode         (result.mode),
        .out_written      (result.duty_written)
    );

endmodule
